/* design/cle_pkg.sv */
package cle_pkg;

    // Line buffer geometry
    localparam int LINE_CHARS = 64;
    localparam int CNT_W      = $clog2(LINE_CHARS);
    localparam int LEN_W      = 6;
    localparam int IDX_W      = 6;
    localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Terminal byte codes
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_DEL = 8'h7F;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_SP  = 8'h20;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    // Result kinds
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Input item functions
    typedef enum logic [1:0] {
        FUNC_RX    = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // Work kinds handed to the back end
    typedef enum logic [1:0] {
        OP_CHAR  = 2'd0,
        OP_EOL   = 2'd1,
        OP_ERASE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [7:0]       data;
        logic             ready;
        logic [LEN_W-1:0] length;
    } t_job;

endpackage

/* design/cle_front.sv */
module cle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [15:0]   i_s_tdata,   // [7:0] rx_byte, [13:8] read_index, [15:14] zero
    input  logic [1:0]    i_s_tuser,   // [1:0] func
    output logic          o_push,
    output cle_pkg::t_job o_job,
    input  logic          i_full
);
    import cle_pkg::*;

    logic [7:0]       line_mem [LINE_CHARS];
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ready, n_ready;
    logic             r_stage_v;
    t_job             r_stage, n_stage;
    logic             n_has_job;
    logic             r_hit, n_hit;
    logic [7:0]       r_rd_data;
    logic             n_wr;

    logic             accept;
    t_func            func;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] rd_idx;
    logic             is_eol, is_erase, is_print, not_full;

    assign func    = t_func'(i_s_tuser);
    assign rx_byte = i_s_tdata[7:0];
    assign rd_idx  = i_s_tdata[13:8];

    // Accept while the stage is free or drains this cycle
    assign o_push     = r_stage_v && !i_full;
    assign o_s_tready = !r_stage_v || !i_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // Classify the received byte
    assign is_eol   = (rx_byte == BYTE_CR) || (rx_byte == BYTE_LF);
    assign is_erase = (rx_byte == BYTE_BS) || (rx_byte == BYTE_DEL);
    assign is_print = ((rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI)) || (rx_byte == BYTE_TAB);
    assign not_full = r_count < CNT_W'(LINE_CHARS - 1);

    // Next line state and the job it causes
    always_comb begin
        n_count   = r_count;
        n_ready   = r_ready;
        n_has_job = 1'b0;
        n_wr      = 1'b0;
        n_hit     = CMP_W'(rd_idx) < CMP_W'(r_count);
        n_stage   = '{op: OP_CHAR, data: rx_byte, ready: 1'b0, length: '0};
        unique case (func)
            FUNC_RX: begin
                priority if (is_eol) begin
                    if (r_count != '0) begin
                        n_ready       = 1'b1;
                        n_has_job     = 1'b1;
                        n_stage.op    = OP_EOL;
                    end
                end else if (is_erase) begin
                    if (r_count != '0) begin
                        n_count       = r_count - 1'b1;
                        n_has_job     = 1'b1;
                        n_stage.op    = OP_ERASE;
                    end
                end else if (not_full && is_print) begin
                    n_count       = r_count + 1'b1;
                    n_wr          = 1'b1;
                    n_has_job     = 1'b1;
                    n_stage.op    = OP_CHAR;
                end else begin
                    // Drop control bytes and characters on a full line
                    n_has_job     = 1'b0;
                end
            end
            FUNC_CLEAR: begin
                n_count = '0;
                n_ready = 1'b0;
            end
            FUNC_READ: begin
                n_has_job  = 1'b1;
                n_stage.op = OP_READ;
            end
            FUNC_NONE: begin
            end
            default: begin
            end
        endcase
        n_stage.ready  = n_ready;
        n_stage.length = LEN_W'(n_count);
    end

    // Line state and stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ready   <= 1'b0;
            r_stage_v <= 1'b0;
        end else begin
            if (accept) begin
                r_count   <= n_count;
                r_ready   <= n_ready;
                r_stage_v <= n_has_job;
            end else if (o_push) begin
                r_stage_v <= 1'b0;
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage <= n_stage;
            r_hit   <= n_hit;
        end
    end

    // Line store: write on append, registered read on accept
    always_ff @(posedge i_clk) begin
        if (accept && n_wr) begin
            line_mem[r_count] <= rx_byte;
        end
        if (accept) begin
            r_rd_data <= line_mem[CNT_W'(rd_idx)];
        end
    end

    // Merge read data into the outgoing job
    always_comb begin
        o_job = r_stage;
        if (r_stage.op == OP_READ) begin
            o_job.data = r_hit ? r_rd_data : 8'h00;
        end
    end

endmodule

/* design/cle_queue.sv */
module cle_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cle_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output cle_pkg::t_job o_job,
    output logic          o_empty
);
    import cle_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_fill;

    assign o_full  = r_fill == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_job   = r_slot[r_rd_ptr];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    // Hold queued jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* design/cle_back.sv */
module cle_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cle_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [15:0]   o_m_tdata,   // [7:0] out_byte, [8] line_ready, [14:9] line_length, [15] zero
    output logic          o_m_tlast,
    output logic          o_m_tuser    // [0] kind
);
    import cle_pkg::*;

    logic       r_busy;
    t_job       r_job;
    logic [1:0] r_step;
    logic [7:0] out_byte;
    logic       out_kind;
    logic       out_last;
    logic       m_accept;

    // Expand the current job into its result items
    always_comb begin
        out_kind = KIND_ECHO;
        out_byte = r_job.data;
        out_last = 1'b1;
        unique case (r_job.op)
            OP_CHAR: begin
            end
            OP_EOL: begin
                out_byte = (r_step == 2'd0) ? BYTE_CR : BYTE_LF;
                out_last = r_step == 2'd1;
            end
            OP_ERASE: begin
                out_byte = (r_step == 2'd1) ? BYTE_SP : BYTE_BS;
                out_last = r_step == 2'd2;
            end
            OP_READ: begin
                out_kind = KIND_READ;
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = {1'b0, r_job.length, r_job.ready, out_byte};
    assign o_m_tlast  = out_last;
    assign o_m_tuser  = out_kind;
    assign m_accept   = r_busy && i_m_tready;

    // Take the next job once the current one is done
    assign o_pop = !i_empty && (!r_busy || (m_accept && out_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            priority if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (m_accept && out_last) begin
                r_busy <= 1'b0;
            end else if (m_accept) begin
                r_step <= r_step + 1'b1;
            end else begin
                // Hold while idle or stalled
                r_step <= r_step;
            end
        end
    end

    // Load job payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

endmodule

/* design/console_line_editor.sv */
// Console line editor. Each input item (func in tuser) is a received terminal
// byte, a clear, a read of one stored character or a no-op; result items are echo
// bytes (kind 0) or a read answer (kind 1), each carrying the line-ready flag
// and line length after that item, with tlast on the final result of an item.
// A received byte yields zero to three echo items (one for a stored
// character, CR LF for a line end, BS space BS for an erase); clear, no-op and
// ignored bytes yield none. Input items are taken one per cycle while the
// four-entry job queue between the input front end and the output expander
// has room; the expander sends one result per cycle while tready is high, and
// an item has at most three results. A result passes the front end's stage
// register and registered line-store read, a queue slot and the expander's
// job register. The line store needs no clearing after reset.
module console_line_editor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] rx_byte, [13:8] read_index, [15:14] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [8] line_ready, [14:9] line_length, [15] zero
    output logic        o_m_tlast,
    output logic        o_m_tuser    // [0] kind
);
    import cle_pkg::*;

    logic push, full, pop, empty;
    t_job front_job, queue_job;

    cle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_push     (push),
        .o_job      (front_job),
        .i_full     (full)
    );

    cle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (empty)
    );

    cle_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (queue_job),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

/* design/cle_checker.sv */
module cle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);
    import cle_pkg::*;

    // Nothing comes out right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result withdrawn while stalled");

    // A read answer is always the only result of its item
    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_READ) |-> o_m_tlast)
        else $error("read answer without tlast");

    // A CR echo is always followed by LF
    a_cr_then_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && (o_m_tuser == KIND_ECHO)
        && (o_m_tdata[7:0] == BYTE_CR)
        |-> !o_m_tlast ##1 (o_m_tdata[7:0] == BYTE_LF))
        else $error("CR echo not followed by LF");

endmodule

bind console_line_editor cle_checker u_cle_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

/* dv/console_line_editor_test.sv */
`timescale 1ns / 100ps

module console_line_editor_test;

    import cle_pkg::*;

    // One echo or read-answer item as seen on the master side
    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic             last;
        logic             ready;
        logic [LEN_W-1:0] length;
    } t_term_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [7:0] rx_byte, [13:8] read_index, [15:14] zero
    logic [1:0]  i_s_tuser  = '0;   // [1:0] func
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [7:0] out_byte, [8] line_ready, [14:9] line_length, [15] zero
    logic        o_m_tlast;
    logic        o_m_tuser;         // [0] kind

    // Line state kept by the predictor
    logic [7:0]   line_chars [LINE_CHARS];
    int           line_len  = 0;
    logic         line_done = 1'b0;

    t_term_result pending_results [$];
    int           error_count = 0;
    bit           stall_en    = 1'b1;

    console_line_editor u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count a failure, report only the first few
    function automatic void note_failure(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Random printable byte, sometimes a tab
    function automatic logic [7:0] rand_printable();
        if ($urandom_range(0, 9) == 0) begin
            return BYTE_TAB;
        end
        return 8'($urandom_range(PRINT_LO, PRINT_HI));
    endfunction

    // Apply one accepted item to the line and queue the results it causes
    task automatic edit_line(t_func func, logic [7:0] rx, logic [IDX_W-1:0] idx);
        logic [7:0]   echo_bytes [3];
        int           n;
        logic         kind;
        t_term_result r;
        n    = 0;
        kind = KIND_ECHO;
        case (func)
            FUNC_RX: begin
                if (rx == BYTE_CR || rx == BYTE_LF) begin
                    if (line_len > 0) begin
                        line_done     = 1'b1;
                        echo_bytes[0] = BYTE_CR;
                        echo_bytes[1] = BYTE_LF;
                        n             = 2;
                    end
                end else if (rx == BYTE_BS || rx == BYTE_DEL) begin
                    if (line_len > 0) begin
                        line_len--;
                        echo_bytes[0] = BYTE_BS;
                        echo_bytes[1] = BYTE_SP;
                        echo_bytes[2] = BYTE_BS;
                        n             = 3;
                    end
                end else if (line_len < LINE_CHARS - 1 &&
                             ((rx >= PRINT_LO && rx <= PRINT_HI) || rx == BYTE_TAB)) begin
                    line_chars[line_len] = rx;
                    line_len++;
                    echo_bytes[0] = rx;
                    n             = 1;
                end
            end
            FUNC_CLEAR: begin
                line_len  = 0;
                line_done = 1'b0;
            end
            FUNC_READ: begin
                kind          = KIND_READ;
                echo_bytes[0] = (idx < line_len) ? line_chars[idx] : 8'h00;
                n             = 1;
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++) begin
            r.kind   = kind;
            r.data   = echo_bytes[k];
            r.last   = (k == n - 1);
            r.ready  = line_done;
            r.length = line_len[LEN_W-1:0];
            pending_results.push_back(r);
        end
    endtask

    // Offer one item, wait for the handshake, then predict
    task automatic send_item(t_func func, logic [7:0] rx, logic [IDX_W-1:0] idx);
        if (stall_en && $urandom_range(0, 99) < 33) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {2'b00, idx, rx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        edit_line(func, rx, idx);
    endtask

    // Fields that the function ignores carry random junk
    task automatic send_rx(logic [7:0] rx);
        send_item(FUNC_RX, rx, 6'($urandom));
    endtask

    task automatic send_read(logic [IDX_W-1:0] idx);
        send_item(FUNC_READ, 8'($urandom), idx);
    endtask

    task automatic send_clear();
        send_item(FUNC_CLEAR, 8'($urandom), 6'($urandom));
    endtask

    // Compare one result item with the oldest expectation
    task automatic check_result();
        t_term_result want;
        t_term_result got;
        got.kind   = o_m_tuser;
        got.data   = o_m_tdata[7:0];
        got.last   = o_m_tlast;
        got.ready  = o_m_tdata[8];
        got.length = o_m_tdata[14:9];
        if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected item kind=%0d byte=%02h last=%0d rdy=%0d len=%0d",
                                   got.kind, got.data, got.last, got.ready, got.length));
        end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
                note_failure($sformatf({"exp kind=%0d byte=%02h last=%0d rdy=%0d len=%0d, ",
                                        "got kind=%0d byte=%02h last=%0d rdy=%0d len=%0d"},
                                       want.kind, want.data, want.last, want.ready,
                                       want.length, got.kind, got.data, got.last,
                                       got.ready, got.length));
            end
        end
    endtask

    // Sample results and stall the master side at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            check_result();
        end
        i_m_tready <= stall_en ? ($urandom_range(0, 99) >= 33) : 1'b1;
    end

    // Edits that an empty line must ignore, reads past the end
    task automatic test_empty_line();
        send_read(6'd0);
        send_read(6'd63);
        send_rx(BYTE_CR);
        send_rx(BYTE_LF);
        send_rx(BYTE_BS);
        send_rx(BYTE_DEL);
        send_clear();
        send_item(FUNC_NONE, 8'hFF, 6'h3F);
    endtask

    // Store edge characters, drop control bytes, erase
    task automatic test_typing_and_erase();
        send_rx(PRINT_LO);
        send_rx(PRINT_HI);
        send_rx(BYTE_TAB);
        send_rx(8'h00);
        send_rx(8'h1F);
        send_rx(8'h80);
        send_rx(8'hFF);
        send_read(6'd0);
        send_read(6'd2);
        send_read(6'd3);
        send_rx(BYTE_BS);
        send_rx(BYTE_DEL);
        send_read(6'd1);
    endtask

    // End the line twice, keep editing, then take it
    task automatic test_line_end();
        send_rx(BYTE_CR);
        send_rx(BYTE_LF);
        send_rx(8'h41);
        send_rx(BYTE_BS);
        send_clear();
        send_read(6'd0);
    endtask

    // Fill the line without idling, then push past the limit
    task automatic test_line_full();
        stall_en = 1'b0;
        send_clear();
        while (line_len < LINE_CHARS - 1) send_rx(rand_printable());
        send_rx(8'h41);
        send_rx(BYTE_TAB);
        send_read(6'd62);
        send_read(6'd63);
        send_rx(BYTE_LF);
        send_rx(BYTE_DEL);
        send_rx(rand_printable());
        send_read(6'd62);
        send_clear();
        stall_en = 1'b1;
    endtask

    // Mostly typing with edits, some noise and stray codes
    task automatic test_random_edits();
        int pick;
        for (int i = 0; i < 10; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                send_rx(rand_printable());
            end else if (pick < 58) begin
                send_rx($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
            end else if (pick < 66) begin
                send_rx($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
            end else if (pick < 80) begin
                if (line_len > 0 && $urandom_range(0, 1)) begin
                    send_read(6'($urandom_range(0, line_len - 1)));
                end else begin
                    send_read(6'($urandom));
                end
            end else if (pick < 85) begin
                send_clear();
            end else if (pick < 95) begin
                send_rx(8'($urandom));
            end else begin
                send_item(FUNC_NONE, 8'($urandom), 6'($urandom));
            end
        end
    endtask

    initial begin
        int waited;
        waited = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_line();
        test_typing_and_erase();
        test_line_end();
        test_line_full();
        test_random_edits();
        i_s_tvalid <= 1'b0;
        // Drain the outstanding results, then let the pipeline settle
        while (pending_results.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_results.size() > 0) begin
            note_failure($sformatf("%0d expected items never arrived",
                                   pending_results.size()));
        end
        if (error_count == 0) begin
            $display("PASS console_line_editor");
        end else begin
            $display("FAIL console_line_editor");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #2000000;
        $display("FAIL console_line_editor");
        $finish;
    end

endmodule

/* sim.f */
design/cle_pkg.sv
design/cle_front.sv
design/cle_queue.sv
design/cle_back.sv
design/console_line_editor.sv
design/cle_checker.sv
dv/console_line_editor_test.sv
